// ----- design/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and codes of the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    // Built pool size and configuration register layout
    localparam int          SLOT_COUNT_DEF = 256;
    localparam int          CFG_W          = 9;
    localparam logic [8:0]  CFG_RESET      = 9'd256;

    // Operation codes carried on the slave tuser
    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_RELEASE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP   = 2'd2;

    // Status codes carried on the master tuser
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Beat widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    // Sequencer states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

// ----- design/ght_ram.sv -----
// ----------------------------------------------------------------------------
// ght_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ght_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data valid in the cycle after the read enable
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- design/generational_handle_table.sv -----
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot pool that hands out generation-tagged 32-bit handles.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the operation (register, release, look up),
//   tdata carries the descriptor (bits 31:0) and the handle (bits 63:32).
//   Master stream: tuser carries the status, tdata carries the new handle,
//   the stored descriptor and the slot number. Every input beat makes exactly
//   one output beat.
//   A handle is {generation[15:0], slot + 1}. Register takes the lowest free
//   slot below min(slots_in_use, SLOT_COUNT); release bumps the generation.
//   Timing: an item is accepted and the generation and descriptor RAMs are read
//   at that edge; when the item leaves execute, the result is written back and
//   loaded into the output register. The single read-modify-write through the
//   RAM read port lets a new item in only after the last one leaves execute.
//   The output register frees the slave side: a new item is taken while the
//   previous result waits. If the receiver stalls with a result still held, the
//   next item waits in its execute cycle until the output register drains.
//   Reset clears all slot marks and generations at once (per-slot valid bits),
//   sets slots_in_use to 256 and needs no clearing pass. The configuration
//   register is written whenever i_cfg_wen is high.
// ----------------------------------------------------------------------------
module generational_handle_table #(
    parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF,
    parameter int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Configuration: slots_in_use
    input  logic                            i_cfg_wen,
    input  logic [ght_pkg::CFG_W-1:0]       i_cfg_wdata,

    // Request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ght_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // descriptor_in, handle_in
    input  logic [1:0]                      s_axis_tuser,  // operation

    // Response stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ght_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // handle_out, descriptor_out,
                                                           // slot_index
    output logic [1:0]                      m_axis_tuser   // status
);

    import ght_pkg::*;

    localparam logic [16:0] SlotMax = 17'(SLOT_COUNT);

    // Control registers
    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_cfg;
    logic [SLOT_COUNT-1:0] r_taken;
    logic [SLOT_COUNT-1:0] r_gvalid;
    logic                  r_out_valid;

    // Per-item context captured at accept
    logic [1:0]            r_op;
    logic                  r_addr_ok;
    logic [1:0]            r_fix_status;
    logic [15:0]           r_hgen;
    logic [30:0]           r_desc;
    logic [ADDR_W-1:0]     r_slot;
    logic                  r_taken_hit;
    logic                  r_gen_hit;

    // Output payload
    logic [1:0]            r_out_user;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Combinational signals
    logic                  w_accept;
    logic                  w_done;
    logic [16:0]           w_eff;
    logic [15:0]           w_hidx;
    logic                  w_hidx_ok;
    logic                  w_free_found;
    logic [ADDR_W-1:0]     w_free_idx;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic                  w_pre_ok;
    logic [1:0]            w_pre_status;
    logic [15:0]           w_gen_rd;
    logic [30:0]           w_desc_rd;
    logic [15:0]           w_gen_cur;
    logic [1:0]            w_status;
    logic [31:0]           w_hout;
    logic [31:0]           w_dout;
    logic [7:0]            w_sout;
    logic                  w_desc_we;
    logic                  w_gen_we;
    logic                  w_set_taken;
    logic                  w_clr_taken;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_done        = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    // Effective pool size, clamped to the built size
    assign w_eff = ({8'd0, r_cfg} > SlotMax) ? SlotMax : {8'd0, r_cfg};

    // Slot named by the handle
    assign w_hidx    = s_axis_tdata[47:32] - 16'd1;
    assign w_hidx_ok = ({1'b0, w_hidx} < w_eff);

    // Lowest free slot inside the active range
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_taken[i] && (17'(i) < w_eff)) begin
                w_free_found = 1'b1;
                w_free_idx   = ADDR_W'(i);
            end
        end
    end

    // Decide what can be settled before the RAM read
    always_comb begin
        w_pre_ok     = 1'b0;
        w_pre_status = ST_INVALID;
        w_rd_addr    = ADDR_W'(w_hidx);
        unique case (s_axis_tuser) inside
            OP_REGISTER: begin
                w_rd_addr = w_free_idx;
                if (s_axis_tdata[31]) begin
                    w_pre_status = ST_INVALID;
                end else if (!w_free_found) begin
                    w_pre_status = ST_FULL;
                end else begin
                    w_pre_ok = 1'b1;
                end
            end
            OP_RELEASE, OP_LOOKUP: begin
                w_pre_ok = w_hidx_ok;
            end
            default: begin
                w_pre_ok = 1'b0;
            end
        endcase
    end

    // Generation and descriptor stores
    ght_ram #(
        .WIDTH  (16),
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (ADDR_W)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (w_gen_we),
        .i_waddr (r_slot),
        .i_wdata (w_gen_cur + 16'd1),
        .i_re    (w_accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_gen_rd)
    );

    ght_ram #(
        .WIDTH  (31),
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (ADDR_W)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (w_desc_we),
        .i_waddr (r_slot),
        .i_wdata (r_desc),
        .i_re    (w_accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_desc_rd)
    );

    // A generation never written reads as zero
    assign w_gen_cur = r_gen_hit ? w_gen_rd : 16'd0;

    // Build the result and the write-back
    always_comb begin
        w_status    = r_fix_status;
        w_hout      = '0;
        w_dout      = '0;
        w_sout      = '0;
        w_desc_we   = 1'b0;
        w_gen_we    = 1'b0;
        w_set_taken = 1'b0;
        w_clr_taken = 1'b0;
        if (r_addr_ok) begin
            if (r_op == OP_REGISTER) begin
                w_status    = ST_OK;
                w_hout      = {w_gen_cur, 16'(r_slot) + 16'd1};
                w_sout      = 8'(r_slot);
                w_desc_we   = w_done;
                w_set_taken = w_done;
            end else if (w_gen_cur != r_hgen) begin
                w_status = ST_MISMATCH;
            end else begin
                w_status = ST_OK;
                w_dout   = r_taken_hit ? {1'b0, w_desc_rd} : '1;
                w_sout   = 8'(r_slot);
                if (r_op == OP_RELEASE) begin
                    w_gen_we    = w_done;
                    w_clr_taken = w_done;
                end
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_taken     <= '0;
            r_gvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                r_cfg <= i_cfg_wdata;
            end
            if (w_set_taken) begin
                r_taken[r_slot] <= 1'b1;
            end
            if (w_clr_taken) begin
                r_taken[r_slot] <= 1'b0;
            end
            if (w_gen_we) begin
                r_gvalid[r_slot] <= 1'b1;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the item context at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op         <= s_axis_tuser;
            r_addr_ok    <= w_pre_ok;
            r_fix_status <= w_pre_status;
            r_hgen       <= s_axis_tdata[63:48];
            r_desc       <= s_axis_tdata[30:0];
            r_slot       <= w_rd_addr;
            r_taken_hit  <= r_taken[w_rd_addr];
            r_gen_hit    <= r_gvalid[w_rd_addr];
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_user <= w_status;
            r_out_data <= {w_sout, w_dout, w_hout};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An accepted item always moves into execute
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execute");

    // No new item while one is in execute
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !s_axis_tready)
        else $error("slave ready while an item is in execute");

    // A failed request carries an all-zero payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
        else $error("non-zero payload on a failed request");

    // A successful register marks its slot taken
    a_reg_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_set_taken) |=> r_taken[$past(r_slot)])
        else $error("registered slot not marked taken");

    // A successful release frees its slot
    a_rel_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_clr_taken) |=> !r_taken[$past(r_slot)])
        else $error("released slot still marked taken");

endmodule
